[rtl/pid_differential_drive_unit_defines.svh]
// assertion macros for the pid differential drive unit
`ifndef PID_DIFFERENTIAL_DRIVE_UNIT_DEFINES_SVH
`define PID_DIFFERENTIAL_DRIVE_UNIT_DEFINES_SVH

`ifndef SYNTH

// condition checked at every clock edge outside reset
`define PDD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("pdd assertion failed");

// consequence checked in the cycle after the trigger, outside reset
`define PDD_ASSERT_NEXT(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("pdd assertion failed");

`else

`define PDD_ASSERT(label, clk, rst, prop)
`define PDD_ASSERT_NEXT(label, clk, rst, trig, cons)

`endif

`endif

[rtl/pdd_pkg.sv]
// shared types and constants of the pid differential drive unit
package pdd_pkg;

   localparam int SETPOINT_W     = 8;
   localparam int GAIN_W         = 24;
   localparam int SPEED_W        = 10;
   localparam int DUTY_W         = 10;
   localparam int SUM_W          = 13;
   localparam int SUM_SCALED_W   = 20;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 24;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SETPOINT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_P     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_I     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_D     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_SPEED = 3'd4;

   // register defaults
   localparam logic [SETPOINT_W-1:0] SETPOINT_RESET   = 8'd85;
   localparam logic [GAIN_W-1:0]     GAIN_P_RESET     = 24'd76800;
   localparam logic [GAIN_W-1:0]     GAIN_I_RESET     = 24'd0;
   localparam logic [GAIN_W-1:0]     GAIN_D_RESET     = 24'd51;
   localparam logic [SPEED_W-1:0]    BASE_SPEED_RESET = 10'd500;

   localparam logic signed [SUM_W-1:0] INTEGRAL_LIMIT = 13'sd3000;
   localparam logic [DUTY_W-1:0]       DUTY_LIMIT     = 10'd1000;

   // divisor 100 * 2^F split as 2^(F+2) * 25
   localparam int P_DIVISOR_LOG2 = 2;

   // correction magnitude is clamped to 11 bits, enough to saturate both motors
   localparam int QUOT_W = 11;
   localparam int QIN_W  = 16;
   localparam logic [QIN_W-1:0] QIN_MAX = 16'd51199;

   // floor(q / 25) = (q * 83887) >> 21 for q below 51200
   localparam int RECIP_W     = 17;
   localparam int RECIP_SHIFT = 21;
   localparam logic [RECIP_W-1:0] RECIP_MULT = 17'd83887;

   localparam int CMD_W = 13;

   typedef struct packed {
      logic [SETPOINT_W-1:0] setpoint;
      logic [GAIN_W-1:0]     gain_p;
      logic [GAIN_W-1:0]     gain_i;
      logic [GAIN_W-1:0]     gain_d;
      logic [SPEED_W-1:0]    base_speed;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic             negative;
      logic [QIN_W-1:0] quot_in;
   } quot_stage_type;

endpackage

[rtl/pdd_if.sv]
// request and response channel interfaces of the pid differential drive unit
interface pdd_req_if #(
   parameter int POSITION_BITS = 8
);
   logic                     valid;
   logic                     ready;
   logic [POSITION_BITS-1:0] position;

   modport source (output valid, output position, input ready);
   modport sink   (input valid, input position, output ready);
endinterface

interface pdd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pdd_pkg::DUTY_W-1:0]  left_duty;
   logic                        left_reverse;
   logic [pdd_pkg::DUTY_W-1:0]  right_duty;
   logic                        right_reverse;

   modport source (output valid, output left_duty, output left_reverse,
                   output right_duty, output right_reverse, input ready);
   modport sink   (input valid, input left_duty, input left_reverse,
                   input right_duty, input right_reverse, output ready);
endinterface

[rtl/pid_differential_drive_unit.sv]
// top level of the pid line follower with differential drive mixing
//
//   channel  direction  handshake               payload
//   req_if   in         valid / ready           position
//   rsp_if   out        valid / ready           left_duty, left_reverse,
//                                               right_duty, right_reverse
//   csr      in         csr_write_enable        csr_index, csr_write_data
//
// one transaction per cycle sustained while the response side is not stalled;
// each request passes the three register stages (error, gain products, mix)
// reset is synchronous: clears stage valids, integral and last error, and
// loads the register defaults
// each stage refills as soon as it empties, so ready falls only when all
// three stages hold a transaction and the response side is stalled
`include "pid_differential_drive_unit_defines.svh"

module pid_differential_drive_unit #(
   parameter int POSITION_BITS  = 8,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   pdd_req_if.sink                          req_if,
   pdd_rsp_if.source                        rsp_if,
   input  logic                             csr_write_enable,
   input  logic [pdd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pdd_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import pdd_pkg::*;

   // error is one bit wider than the wider of setpoint and position
   localparam int ERR_W = ((POSITION_BITS > SETPOINT_W) ? POSITION_BITS : SETPOINT_W) + 1;

   cfg_type                          cfg;
   logic                             err_valid;
   logic signed [ERR_W-1:0]          err;
   logic signed [SUM_SCALED_W-1:0]   sum_scaled;
   logic signed [ERR_W+4:0]          deriv_scaled;
   logic                             product_take;
   logic                             mix_take;
   quot_stage_type                   quot_stage;

   // configuration registers
   pdd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // stage one: error, clamped integral, derivative, state update on accept
   pdd_error #(
      .ERR_W         (ERR_W)
   ) u_error (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .setpoint     (cfg.setpoint),
      .next_take    (product_take),
      .stage_valid  (err_valid),
      .err          (err),
      .sum_scaled   (sum_scaled),
      .deriv_scaled (deriv_scaled)
   );

   // stage two: three gain products, their sum and the power of two scaling
   pdd_product #(
      .ERR_W          (ERR_W),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_product (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (err_valid),
      .err          (err),
      .sum_scaled   (sum_scaled),
      .deriv_scaled (deriv_scaled),
      .cfg          (cfg),
      .next_take    (mix_take),
      .take         (product_take),
      .quot_stage   (quot_stage)
   );

   // stage three: divide by 25, add and subtract from base speed, saturate
   pdd_mix u_mix (
      .clock      (clock),
      .reset      (reset),
      .quot_stage (quot_stage),
      .base_speed (cfg.base_speed),
      .take       (mix_take),
      .rsp_if     (rsp_if)
   );

   // back-pressure only when the whole pipe is full
   `PDD_ASSERT(a_ready_only_when_full, clock, reset,
      !req_if.ready |-> (err_valid && quot_stage.valid && rsp_if.valid))
   // left and right commands sum to twice the base speed, never both negative
   `PDD_ASSERT(a_not_both_reverse, clock, reset,
      rsp_if.valid |-> !(rsp_if.left_reverse && rsp_if.right_reverse))
   // duty saturation
   `PDD_ASSERT(a_duty_limit, clock, reset,
      rsp_if.valid |-> ((rsp_if.left_duty <= DUTY_LIMIT) && (rsp_if.right_duty <= DUTY_LIMIT)))

endmodule

[rtl/pdd_csr.sv]
// configuration register bank
module pdd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [pdd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pdd_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output pdd_pkg::cfg_type                 cfg
);
   import pdd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_SETPOINT:   cfg_in.setpoint   = csr_write_data[SETPOINT_W-1:0];
            REG_GAIN_P:     cfg_in.gain_p     = csr_write_data[GAIN_W-1:0];
            REG_GAIN_I:     cfg_in.gain_i     = csr_write_data[GAIN_W-1:0];
            REG_GAIN_D:     cfg_in.gain_d     = csr_write_data[GAIN_W-1:0];
            REG_BASE_SPEED: cfg_in.base_speed = csr_write_data[SPEED_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint   <= SETPOINT_RESET;
         cfg_ff.gain_p     <= GAIN_P_RESET;
         cfg_ff.gain_i     <= GAIN_I_RESET;
         cfg_ff.gain_d     <= GAIN_D_RESET;
         cfg_ff.base_speed <= BASE_SPEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/pdd_error.sv]
// error, integral and derivative stage with the controller state
`include "pid_differential_drive_unit_defines.svh"

module pdd_error #(
   parameter int ERR_W         = 9
) (
   input  logic                                    clock,
   input  logic                                    reset,
   pdd_req_if.sink                                 req_if,
   input  logic [pdd_pkg::SETPOINT_W-1:0]          setpoint,
   input  logic                                    next_take,
   output logic                                    stage_valid,
   output logic signed [ERR_W-1:0]                 err,
   output logic signed [pdd_pkg::SUM_SCALED_W-1:0] sum_scaled,
   output logic signed [ERR_W+4:0]                 deriv_scaled
);
   import pdd_pkg::*;

   localparam int DERIV_W = ERR_W + 1;
   localparam int D10_W   = ERR_W + 5;
   localparam int ACC_W   = ((ERR_W > SUM_W) ? ERR_W : SUM_W) + 1;
   localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(INTEGRAL_LIMIT);
   localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_HI;

   logic                            valid_ff;
   logic signed [SUM_W-1:0]         sum_ff;
   logic signed [SUM_W-1:0]         sum_in;
   logic signed [ERR_W-1:0]         prev_ff;
   logic signed [ERR_W-1:0]         err_ff;
   logic signed [SUM_SCALED_W-1:0]  sum_scaled_ff;
   logic signed [D10_W-1:0]         deriv_scaled_ff;

   logic                            take;
   logic                            accept;
   logic signed [ERR_W-1:0]         err_new;
   logic signed [DERIV_W-1:0]       deriv_new;
   logic signed [ACC_W-1:0]         acc;
   logic signed [ACC_W-1:0]         acc_clamped;
   logic signed [SUM_SCALED_W-1:0]  sum_ext;
   logic signed [SUM_SCALED_W-1:0]  sum_scaled_in;
   logic signed [D10_W-1:0]         deriv_ext;
   logic signed [D10_W-1:0]         deriv_scaled_in;

   assign take         = !valid_ff || next_take;
   assign req_if.ready = take;
   assign accept       = req_if.valid && take;

   assign err_new   = $signed(ERR_W'(setpoint)) - $signed(ERR_W'(req_if.position));
   assign deriv_new = $signed(DERIV_W'(err_new)) - $signed(DERIV_W'(prev_ff));
   assign acc       = $signed(ACC_W'(sum_ff)) + $signed(ACC_W'(err_new));

   always_comb begin
      if (acc > ACC_HI) begin
         acc_clamped = ACC_HI;
      end else if (acc < ACC_LO) begin
         acc_clamped = ACC_LO;
      end else begin
         acc_clamped = acc;
      end
   end

   assign sum_in = SUM_W'(acc_clamped);

   // times 100 and times 10 by shifts
   assign sum_ext         = $signed(SUM_SCALED_W'(sum_in));
   assign sum_scaled_in   = (sum_ext <<< 6) + (sum_ext <<< 5) + (sum_ext <<< 2);
   assign deriv_ext       = $signed(D10_W'(deriv_new));
   assign deriv_scaled_in = (deriv_ext <<< 3) + (deriv_ext <<< 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sum_ff   <= '0;
         prev_ff  <= '0;
      end else begin
         if (take) begin
            valid_ff <= req_if.valid;
         end
         if (accept) begin
            sum_ff  <= sum_in;
            prev_ff <= err_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         err_ff          <= err_new;
         sum_scaled_ff   <= sum_scaled_in;
         deriv_scaled_ff <= deriv_scaled_in;
      end
   end

   assign stage_valid  = valid_ff;
   assign err          = err_ff;
   assign sum_scaled   = sum_scaled_ff;
   assign deriv_scaled = deriv_scaled_ff;

   `PDD_ASSERT(a_integral_range, clock, reset,
      (sum_ff <= INTEGRAL_LIMIT) && (sum_ff >= -INTEGRAL_LIMIT))
   `PDD_ASSERT_NEXT(a_accept_fills_stage, clock, reset, accept, valid_ff)
   `PDD_ASSERT_NEXT(a_stall_keeps_state, clock, reset, !accept,
      $stable(sum_ff) && $stable(prev_ff))

endmodule

[rtl/pdd_product.sv]
// gain products, sum and magnitude scaling of the correction
module pdd_product #(
   parameter int ERR_W          = 9,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   input  logic signed [ERR_W-1:0]                 err,
   input  logic signed [pdd_pkg::SUM_SCALED_W-1:0] sum_scaled,
   input  logic signed [ERR_W+4:0]                 deriv_scaled,
   input  pdd_pkg::cfg_type                        cfg,
   input  logic                                    next_take,
   output logic                                    take,
   output pdd_pkg::quot_stage_type                 quot_stage
);
   import pdd_pkg::*;

   localparam int P_W        = GAIN_W + 1 + ERR_W;
   localparam int I_W        = GAIN_W + 1 + SUM_SCALED_W;
   localparam int D_W        = GAIN_W + ERR_W + 6;
   localparam int PI_W       = (P_W > I_W) ? P_W : I_W;
   localparam int NUM_W      = ((PI_W > D_W) ? PI_W : D_W) + 2;
   localparam int QUOT_SHIFT = GAIN_FRAC_BITS + P_DIVISOR_LOG2;

   logic                      valid_ff;
   logic                      negative_ff;
   logic [QIN_W-1:0]          quot_in_ff;

   logic signed [GAIN_W:0]    gain_p_s;
   logic signed [GAIN_W:0]    gain_i_s;
   logic signed [GAIN_W:0]    gain_d_s;
   logic signed [P_W-1:0]     term_p;
   logic signed [I_W-1:0]     term_i;
   logic signed [D_W-1:0]     term_d;
   logic signed [NUM_W-1:0]   num;
   logic [NUM_W-1:0]          num_mag;
   logic [NUM_W-1:0]          num_shifted;
   logic [QIN_W-1:0]          quot_in_new;

   assign take = !valid_ff || next_take;

   assign gain_p_s = $signed({1'b0, cfg.gain_p});
   assign gain_i_s = $signed({1'b0, cfg.gain_i});
   assign gain_d_s = $signed({1'b0, cfg.gain_d});

   assign term_p = gain_p_s * err;
   assign term_i = gain_i_s * sum_scaled;
   assign term_d = gain_d_s * deriv_scaled;

   assign num = $signed(NUM_W'(term_p)) + $signed(NUM_W'(term_i))
              + $signed(NUM_W'(term_d));

   // truncation toward zero: divide the magnitude, keep the sign apart
   assign num_mag     = num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);
   assign num_shifted = num_mag >> QUOT_SHIFT;
   assign quot_in_new = (num_shifted > NUM_W'(QIN_MAX)) ? QIN_MAX
                                                         : num_shifted[QIN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_valid) begin
         negative_ff <= num[NUM_W-1];
         quot_in_ff  <= quot_in_new;
      end
   end

   assign quot_stage.valid    = valid_ff;
   assign quot_stage.negative = negative_ff;
   assign quot_stage.quot_in  = quot_in_ff;

endmodule

[rtl/pdd_mix.sv]
// final division by 25, differential mixing and result register
module pdd_mix (
   input  logic                          clock,
   input  logic                          reset,
   input  pdd_pkg::quot_stage_type       quot_stage,
   input  logic [pdd_pkg::SPEED_W-1:0]   base_speed,
   output logic                          take,
   pdd_rsp_if.source                     rsp_if
);
   import pdd_pkg::*;

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic              reverse;
   } motor_type;

   function automatic motor_type motor_drive(input logic signed [CMD_W-1:0] cmd);
      logic [CMD_W-1:0] mag;
      motor_type        motor;
      mag           = cmd[CMD_W-1] ? $unsigned(-cmd) : $unsigned(cmd);
      motor.reverse = cmd[CMD_W-1];
      motor.duty    = (mag > CMD_W'(DUTY_LIMIT)) ? DUTY_LIMIT : mag[DUTY_W-1:0];
      return motor;
   endfunction

   logic                          valid_ff;
   motor_type                     left_ff;
   motor_type                     right_ff;

   logic [QIN_W+RECIP_W-1:0]      recip_prod;
   logic [QUOT_W-1:0]             quot;
   logic signed [CMD_W-1:0]       corr;
   logic signed [CMD_W-1:0]       base_s;
   logic signed [CMD_W-1:0]       left_cmd;
   logic signed [CMD_W-1:0]       right_cmd;
   motor_type                     left_in;
   motor_type                     right_in;

   assign take = !valid_ff || rsp_if.ready;

   assign recip_prod = quot_stage.quot_in * RECIP_MULT;
   assign quot       = recip_prod[RECIP_SHIFT +: QUOT_W];
   assign corr       = quot_stage.negative ? -$signed(CMD_W'(quot)) : $signed(CMD_W'(quot));
   assign base_s     = $signed(CMD_W'(base_speed));
   assign left_cmd   = base_s + corr;
   assign right_cmd  = base_s - corr;
   assign left_in    = motor_drive(left_cmd);
   assign right_in   = motor_drive(right_cmd);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= quot_stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take && quot_stage.valid) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.left_duty     = left_ff.duty;
   assign rsp_if.left_reverse  = left_ff.reverse;
   assign rsp_if.right_duty    = right_ff.duty;
   assign rsp_if.right_reverse = right_ff.reverse;

endmodule
